// File: rtl/sdaf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared widths, ASCII codes and the hand-off type of the scaled decimal
// ASCII formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    // Field widths
    localparam int VAL_W    = 64;
    localparam int SCALE_W  = 5;
    localparam int CHAR_W   = 7;
    localparam int MAX_SCALE = 20;

    // BCD store: 20 value digits plus one spare digit for the "0." position
    // when the scale reaches its maximum
    localparam int NUM_DIG  = 21;
    localparam int BCD_W    = 4 * NUM_DIG;
    localparam int POS_W    = $clog2(NUM_DIG);
    localparam int CNT_W    = $clog2(VAL_W);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

    // Converted job handed from the converter to the character sequencer
    typedef struct packed {
        logic               done;
        logic               neg;
        logic [SCALE_W-1:0] scale;
        logic [BCD_W-1:0]   bcd;
    } sdaf_job_t;

endpackage
`default_nettype wire

// File: rtl/sdaf_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_dabble
// Bit-serial binary to BCD converter (shift and add 3), one magnitude bit
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module sdaf_dabble
    import sdaf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [VAL_W-1:0]   mag,
    input  wire logic               neg,
    input  wire logic [SCALE_W-1:0] scale,
    output logic                    idle,
    output sdaf_job_t               job
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [SCALE_W-1:0] sc_reg, sc_next;
    logic [BCD_W-1:0]   bcd_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Load on start, then shift one bit a cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        sc_next   = sc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mag_next  = mag;
            bcd_next  = '0;
            neg_next  = neg;
            sc_next   = scale;
        end else if (busy_reg) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VAL_W-1]};
            mag_next = {mag_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        sc_reg  <= sc_next;
    end

    assign idle      = !busy_reg && !done_reg;
    assign job.done  = done_reg;
    assign job.neg   = neg_reg;
    assign job.scale = sc_reg;
    assign job.bcd   = bcd_reg;

endmodule
`default_nettype wire

// File: rtl/sdaf_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_emit
// Character sequencer: walks the BCD digits one per cycle from the top while
// the output register is free, skips leading zeros, places sign and point,
// trims the fraction and drives the registered result beat.
// ----------------------------------------------------------------------------
module sdaf_emit
    import sdaf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sdaf_job_t         job,
    output logic                   idle,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_char,
    output logic                   m_last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SIGN  = 4'b0010,
        ST_DIG   = 4'b0100,
        ST_POINT = 4'b1000
    } sdaf_emit_st_t;

    sdaf_emit_st_t      state_reg, state_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SCALE_W-1:0] sc_reg, sc_next;
    logic               lead_reg, lead_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic [3:0]         top_dig;
    logic               rest_zero;
    logic               at_int;
    logic               out_free;
    logic               emit;
    logic [CHAR_W-1:0]  emit_char;
    logic               emit_last;

    assign top_dig   = bcd_reg[BCD_W-1 -: 4];
    assign rest_zero = (bcd_reg[BCD_W-5:0] == '0);
    assign at_int    = (SCALE_W'(pos_reg) > sc_reg);
    assign out_free  = !valid_reg || m_ready;

    // Walk the digits; a leading zero above the point is skipped
    always_comb begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        pos_next   = pos_reg;
        sc_next    = sc_reg;
        lead_next  = lead_reg;
        emit       = 1'b0;
        emit_char  = CH_ZERO;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (job.done) begin
                    bcd_next   = job.bcd;
                    pos_next   = POS_W'(NUM_DIG - 1);
                    sc_next    = job.scale;
                    lead_next  = 1'b1;
                    state_next = job.neg ? ST_SIGN : ST_DIG;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = CH_MINUS;
                    state_next = ST_DIG;
                end
            end
            ST_DIG: begin
                if (lead_reg && (top_dig == 4'd0) && at_int) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
                    pos_next = pos_reg - 1'b1;
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_char = CH_ZERO + {3'b000, top_dig};
                    emit_last = !at_int && rest_zero;
                    lead_next = 1'b0;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
                        pos_next = pos_reg - 1'b1;
                        if (SCALE_W'(pos_reg) == sc_reg) begin
                            state_next = ST_POINT;
                        end
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = CH_POINT;
                    state_next = ST_DIG;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat register: load on emit, drop once taken
    always_comb begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (emit) begin
            valid_next = 1'b1;
            char_next  = emit_char;
            last_next  = emit_last;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        bcd_reg  <= bcd_next;
        pos_reg  <= pos_next;
        sc_reg   <= sc_next;
        lead_reg <= lead_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign idle    = (state_reg == ST_IDLE);
    assign m_valid = valid_reg;
    assign m_char  = char_reg;
    assign m_last  = last_reg;

endmodule
`default_nettype wire

// File: rtl/scaled_decimal_ascii_formatter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_decimal_ascii_formatter_core
// Formats a signed or unsigned 64-bit value with a decimal scale as a stream
// of ASCII characters, one per output beat.
// ----------------------------------------------------------------------------
// One value passes through the bit-serial binary to BCD converter and is
// handed to the sequencer, which skips the leading zero digits and then sends
// one character per beat (1 to 23 characters). The converter shifts one bit a
// cycle and the sequencer handles one digit a cycle while the output is free.
// A new value can be accepted while the last character still sits in the
// output register. Scales above 20 are treated as 20; a zero value always
// gives the single character "0".
// ----------------------------------------------------------------------------
module scaled_decimal_ascii_formatter_core
    import sdaf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beat
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [63:0] value, [68:64] scale, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] is_signed
    // result beat
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] character, [7] zero
    output logic             m_tlast    // last
);

    logic               dab_idle;
    logic               emit_idle;
    logic               start;
    logic [VAL_W-1:0]   in_value;
    logic [SCALE_W-1:0] in_scale;
    logic               in_neg;
    logic [VAL_W-1:0]   in_mag;
    logic [SCALE_W-1:0] in_sc_sat;
    sdaf_job_t          job;
    logic [CHAR_W-1:0]  out_char;

    assign in_value = s_tdata[VAL_W-1:0];
    assign in_scale = s_tdata[VAL_W +: SCALE_W];

    // Take a new value only with both converter and sequencer free
    assign s_tready = dab_idle && emit_idle;
    assign start    = s_tvalid && s_tready;

    // Sign, magnitude and scale saturation
    assign in_neg    = s_tuser[0] && in_value[VAL_W-1];
    assign in_mag    = in_neg ? (~in_value + 1'b1) : in_value;
    assign in_sc_sat = (in_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : in_scale;

    sdaf_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .mag     (in_mag),
        .neg     (in_neg),
        .scale   (in_sc_sat),
        .idle    (dab_idle),
        .job     (job)
    );

    sdaf_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job     (job),
        .idle    (emit_idle),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_char  (out_char),
        .m_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

// File: rtl/sdaf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_checker
// Port-level checks of the formatter: beat hold, character set, sign
// placement and string framing.
// ----------------------------------------------------------------------------
module sdaf_checker
    import sdaf_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    logic [1:0] open_reg, open_next;
    logic first_reg, first_next;
    logic s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Count strings accepted but not yet closed; note when the next beat opens one
    always_comb begin
        first_next = first_reg;
        if (m_acc) begin
            first_next = m_tlast;
        end
        case ({s_acc, m_acc && m_tlast})
            2'b10:   open_next = open_reg + 2'd1;
            2'b01:   open_next = open_reg - 2'd1;
            default: open_next = open_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 2'd0;
            first_reg <= 1'b1;
        end else begin
            open_reg  <= open_next;
            first_reg <= first_next;
        end
    end

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Only digits, point or minus leave the block
    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == 1'b0) &&
            ((m_tdata[6:0] >= CH_ZERO && m_tdata[6:0] <= CH_NINE) ||
             m_tdata[6:0] == CH_POINT || m_tdata[6:0] == CH_MINUS))
        else $error("illegal character");

    // A minus only opens a string and never ends it
    a_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:0] == CH_MINUS) |-> first_reg && !m_tlast)
        else $error("misplaced minus");

    // No result beat without a value in flight
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (open_reg != 2'd0))
        else $error("result beat without input");

    // No new value before the last character is on the output
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (open_reg != 2'd0) && !(m_tvalid && m_tlast) |-> !s_tready)
        else $error("input taken while string in progress");

endmodule

bind scaled_decimal_ascii_formatter_core sdaf_checker u_sdaf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: sim/tb_scaled_decimal_ascii_formatter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_scaled_decimal_ascii_formatter_core
// Drives 64-bit values with sign flag and decimal scale into the formatter
// and checks every ASCII character beat and its last flag. A directed table
// covers zero, the extremes, saturated scales and fraction trimming. A run
// of random values follows. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_scaled_decimal_ascii_formatter_core;
    import sdaf_pkg::*;

    localparam int NUM_DIR      = 24;
    localparam int NUM_RANDOM   = 300;
    localparam int BLOCK_ITEMS  = 50;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 128;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic               sg;
        logic [SCALE_W-1:0] scale;
    } fmt_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [63:0] value, [68:64] scale, rest zero
    logic [0:0]  s_tuser;   // [0] is_signed
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [6:0] character, [7] zero
    logic        m_tlast;   // last

    char_beat_t  pending_chars [$];
    int          error_count;
    int          idle_cycles;
    int          stall_left;
    bit          calm_mode;

    // Directed values: zero, extremes, saturated scale, fraction trimming
    fmt_req_t dir_stim [NUM_DIR] = '{
        {64'd0,                  1'b0, 5'd0},
        {64'd0,                  1'b1, 5'd20},
        {64'd0,                  1'b0, 5'd31},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd0},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd0},
        {64'h8000_0000_0000_0000, 1'b1, 5'd0},
        {64'h8000_0000_0000_0000, 1'b0, 5'd0},
        {64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd0},
        {64'd1,                  1'b0, 5'd20},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd20},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd20},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd31},
        {64'd1000,               1'b0, 5'd3},
        {64'd1500,               1'b0, 5'd3},
        {64'd5,                  1'b0, 5'd1},
        {64'd100,                1'b0, 5'd5},
        {64'd12345,              1'b0, 5'd2},
        {-64'd12345,             1'b1, 5'd2},
        {64'd10,                 1'b0, 5'd19},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd19},
        {64'd7,                  1'b1, 5'd0},
        {64'd42,                 1'b0, 5'd25},
        {64'd10000000000000000000, 1'b0, 5'd19},
        {64'h8000_0000_0000_0000, 1'b1, 5'd20}
    };

    // Expected text where obvious; empty means ask the predictor
    string dir_text [NUM_DIR] = '{
        "0",
        "0",
        "0",
        "18446744073709551615",
        "-1",
        "-9223372036854775808",
        "9223372036854775808",
        "9223372036854775807",
        "0.00000000000000000001",
        "-0.00000000000000000001",
        "0.18446744073709551615",
        "",
        "1",
        "1.5",
        "0.5",
        "0.001",
        "123.45",
        "-123.45",
        "",
        "",
        "7",
        "",
        "",
        ""
    };

    scaled_decimal_ascii_formatter_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (calm_mode) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Queue a text as character beats, last flag on the final one
    function automatic void queue_text(input string text);
        char_beat_t beat;
        for (int i = 0; i < text.len(); i++) begin
            beat.ch   = CHAR_W'(text[i]);
            beat.last = (i == text.len() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    // Work out the decimal text of one value and queue its beats
    function automatic void format_decimal(input logic [VAL_W-1:0] raw, input logic sg,
                                           input logic [SCALE_W-1:0] scale_in);
        logic              neg;
        logic [VAL_W-1:0]  mag;
        logic [CHAR_W-1:0] digs [20];
        logic [CHAR_W-1:0] txt [$];
        char_beat_t        beat;
        int                frac;
        int                n;
        int                start;
        neg  = sg && raw[VAL_W-1];
        mag  = neg ? -raw : raw;
        frac = (scale_in > MAX_SCALE) ? MAX_SCALE : int'(scale_in);
        n    = 0;
        if (mag == 0) begin
            beat.ch   = CH_ZERO;
            beat.last = 1'b1;
            pending_chars.push_back(beat);
            return;
        end
        // Digits, least significant first
        while (mag != 0) begin
            digs[n] = CH_ZERO + CHAR_W'(mag % 10);
            mag     = mag / 10;
            n++;
        end
        if (neg) begin
            txt.push_back(CH_MINUS);
        end
        start = txt.size();
        if (frac == 0) begin
            for (int i = n - 1; i >= 0; i--) txt.push_back(digs[i]);
        end else begin
            if (n <= frac) begin
                txt.push_back(CH_ZERO);
                txt.push_back(CH_POINT);
                for (int i = 0; i < frac - n; i++) txt.push_back(CH_ZERO);
                for (int i = n - 1; i >= 0; i--) txt.push_back(digs[i]);
            end else begin
                for (int i = n - 1; i >= frac; i--) txt.push_back(digs[i]);
                txt.push_back(CH_POINT);
                for (int i = frac - 1; i >= 0; i--) txt.push_back(digs[i]);
            end
            // Trim trailing fraction zeros, then a bare point
            while (txt.size() > start + 1) begin
                if (txt[txt.size()-1] == CH_ZERO) begin
                    void'(txt.pop_back());
                end else begin
                    if (txt[txt.size()-1] == CH_POINT) begin
                        void'(txt.pop_back());
                    end
                    break;
                end
            end
        end
        for (int i = 0; i < txt.size(); i++) begin
            beat.ch   = txt[i];
            beat.last = (i == txt.size() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    // Random value: full width, shortened, scaled by tens, extremes, small negatives
    function automatic fmt_req_t random_request();
        fmt_req_t req;
        int       kind;
        logic [VAL_W-1:0] v;
        v    = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
            end
            3, 4, 5: begin
                v = v >> $urandom_range(1, 63);
            end
            6, 7: begin
                v = VAL_W'($urandom_range(0, 999));
                for (int k = $urandom_range(0, 16); k > 0; k--) v = v * 10;
            end
            8: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = VAL_W'(1);
                    2:       v = '1;
                    3:       v = {1'b1, {(VAL_W-1){1'b0}}};
                    default: v = {1'b0, {(VAL_W-1){1'b1}}};
                endcase
            end
            default: begin
                v = -VAL_W'($urandom_range(1, 100000));
            end
        endcase
        req.value = v;
        req.sg    = 1'($urandom_range(0, 1));
        req.scale = ($urandom_range(0, 9) < 8) ? SCALE_W'($urandom_range(0, MAX_SCALE))
                                               : SCALE_W'($urandom_range(MAX_SCALE + 1, 31));
        return req;
    endfunction

    // Present one value after a random gap and hold it until accepted
    task automatic send_value(input fmt_req_t req, input string text);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req.scale, req.value};
        s_tuser  <= req.sg;
        if (text.len() > 0) begin
            queue_text(text);
        end else begin
            format_decimal(req.value, req.sg, req.scale);
        end
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the input idle until every queued character has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // Result side: stall at random, compare each beat with the oldest expectation
    always @(posedge aclk) begin
        char_beat_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          m_tdata[CHAR_W-1:0], m_tlast));
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.ch) begin
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              m_tdata[CHAR_W-1:0], want.ch));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b (char 0x%02h)",
                                              m_tlast, want.last, want.ch));
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Stop the run when nothing moves for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("tb_scaled_decimal_ascii_formatter_core NOT OK");
        $finish;
    end

    initial begin
        fmt_req_t req;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        stall_left  = 0;
        calm_mode   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (int i = 0; i < NUM_DIR; i++) begin
            send_value(dir_stim[i], dir_text[i]);
        end

        // Random blocks with stalls, one in three in steady flow, drained in between
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % BLOCK_ITEMS == 0) begin
                drain_results();
                calm_mode = ((i / BLOCK_ITEMS) % 3 == 1);
            end
            req = random_request();
            send_value(req, "");
        end
        calm_mode = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("tb_scaled_decimal_ascii_formatter_core OK");
        end else begin
            $display("tb_scaled_decimal_ascii_formatter_core NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
